### hw/rtl/sfp_pkg.sv
// Shared types and constants for the sensor frame parser.
// Used by every module under hw/rtl; depends on nothing.
package sfp_pkg;

    localparam logic [7:0] HEADER_RESET = 8'hAA;
    localparam int         LEN_W        = 3;

    typedef enum logic [5:0] {
        PH_HEAD1 = 6'b000001,
        PH_HEAD2 = 6'b000010,
        PH_CMD   = 6'b000100,
        PH_LEN   = 6'b001000,
        PH_DATA  = 6'b010000,
        PH_SUM   = 6'b100000
    } t_phase;

    typedef enum logic [1:0] {
        ST_GOOD    = 2'd0,
        ST_BADSUM  = 2'd1,
        ST_TOOLONG = 2'd2,
        ST_NOTFOUR = 2'd3
    } t_status;

    typedef struct packed {
        t_status          status;
        logic [7:0]       command_code;
        logic [7:0]       material;
        logic [15:0]      distance;
        logic [7:0]       strength;
        logic [LEN_W-1:0] payload_length;
    } t_result;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } t_byte_item;

endpackage

### hw/rtl/sfp_in_stage.sv
// Input register of the sensor frame parser: holds one received byte.
// Depends on sfp_pkg.
module sfp_in_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [7:0]         i_byte,
    input  logic               i_advance,
    output logic               o_stall,
    output sfp_pkg::t_byte_item o_item
);
    import sfp_pkg::*;

    logic       r_valid;
    logic [7:0] r_byte;

    assign o_stall = r_valid & ~i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_byte <= i_byte;
        end
    end

    assign o_item.valid = r_valid;
    assign o_item.data  = r_byte;

endmodule

### hw/rtl/sfp_parse.sv
// Frame state machine: header hunt, command, length, payload, checksum.
// Depends on sfp_pkg.
module sfp_parse #(
    parameter int MAX_PAYLOAD = 5
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [7:0]          i_header_value,
    input  sfp_pkg::t_byte_item i_item,
    input  logic                i_advance,
    output logic                o_emit,
    output sfp_pkg::t_result    o_result
);
    import sfp_pkg::*;

    t_phase           r_phase,      n_phase;
    logic [7:0]       r_sum,        n_sum;
    logic [7:0]       r_command,    n_command;
    logic [LEN_W-1:0] r_length,     n_length;
    logic [LEN_W-1:0] r_byte_index, n_byte_index;
    logic [7:0]       r_store [MAX_PAYLOAD];

    logic [7:0]       b;
    logic [7:0]       sum_add;
    logic             store_we;

    assign b       = i_item.data;
    assign sum_add = r_sum + b;

    always_comb begin
        n_phase      = r_phase;
        n_sum        = r_sum;
        n_command    = r_command;
        n_length     = r_length;
        n_byte_index = r_byte_index;
        store_we     = 1'b0;
        o_emit       = 1'b0;
        o_result     = '0;
        unique case (r_phase)
            PH_HEAD1: begin
                if (b == i_header_value) begin
                    n_sum   = b;
                    n_phase = PH_HEAD2;
                end
            end
            PH_HEAD2: begin
                if (b == i_header_value) begin
                    n_sum   = sum_add;
                    n_phase = PH_CMD;
                end else begin
                    n_phase = PH_HEAD1;
                end
            end
            PH_CMD: begin
                n_command = b;
                n_sum     = sum_add;
                n_phase   = PH_LEN;
            end
            PH_LEN: begin
                n_length     = b[LEN_W-1:0];
                n_sum        = sum_add;
                n_byte_index = '0;
                if (b > 8'(MAX_PAYLOAD)) begin
                    o_emit   = 1'b1;
                    o_result.status = ST_TOOLONG;
                    n_phase  = PH_HEAD1;
                end else if (b == 8'd0) begin
                    n_phase = PH_SUM;
                end else begin
                    n_phase = PH_DATA;
                end
            end
            PH_DATA: begin
                store_we     = 1'b1;
                n_sum        = sum_add;
                n_byte_index = r_byte_index + 1'b1;
                if (n_byte_index >= r_length) begin
                    n_phase = PH_SUM;
                end
            end
            PH_SUM: begin
                o_emit  = 1'b1;
                n_phase = PH_HEAD1;
                if (b != r_sum) begin
                    o_result.status = ST_BADSUM;
                end else if (r_length != LEN_W'(4)) begin
                    o_result.status = ST_NOTFOUR;
                end else begin
                    o_result.status   = ST_GOOD;
                    o_result.material = r_store[0];
                    o_result.distance = {r_store[2], r_store[1]};
                    o_result.strength = r_store[3];
                end
            end
            default: begin
                n_phase = PH_HEAD1;
            end
        endcase
        o_result.command_code   = n_command;
        o_result.payload_length = n_length;
        if (!i_advance) begin
            o_emit = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HEAD1;
            r_sum        <= '0;
            r_command    <= '0;
            r_length     <= '0;
            r_byte_index <= '0;
        end else if (i_advance) begin
            r_phase      <= n_phase;
            r_sum        <= n_sum;
            r_command    <= n_command;
            r_length     <= n_length;
            r_byte_index <= n_byte_index;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_PAYLOAD; i++) begin
            if (i_advance && store_we && r_byte_index == LEN_W'(i)) begin
                r_store[i] <= b;
            end
        end
    end

    a_emit_at_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit |-> (r_phase == PH_SUM || r_phase == PH_LEN))
        else $error("result emitted outside length or checksum byte");

    a_good_has_four: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_emit && o_result.status == ST_GOOD) |-> (r_length == LEN_W'(4)))
        else $error("good status with payload length not four");

    a_index_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_byte_index < r_length))
        else $error("payload index past frame length");

endmodule

### hw/rtl/sfp_out_stage.sv
// Result register of the sensor frame parser, held while the receiver stalls.
// Depends on sfp_pkg.
module sfp_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_emit,
    input  sfp_pkg::t_result i_result,
    input  logic             i_stall,
    output logic             o_free,
    output logic             o_valid,
    output sfp_pkg::t_result o_result
);
    import sfp_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_free = ~r_valid | ~i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_emit) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

### hw/rtl/sensor_frame_parser.sv
// Sensor frame parser top level: byte input channel, frame result channel,
// header configuration register. Depends on sfp_pkg, sfp_in_stage, sfp_parse,
// sfp_out_stage.
//
// Input channel: i_in_valid / o_in_stall carry one received byte (i_rx_byte).
// A byte is taken at a clock edge with i_in_valid high and o_in_stall low.
// Output channel: o_out_valid / i_out_stall carry one result item per frame
// (status, command, material, distance, strength, payload length).
// Configuration: i_cfg_we writes i_cfg_wdata into the header value register.
// A frame's last byte passes from the input register through the parse stage
// into the result register; throughput is one byte per cycle when the receiver
// does not stall, set by the single parse stage between the two registers.
// When the receiver stalls, the result register holds; the parse stage waits
// and o_in_stall rises once the input register is also occupied.
// Reset (synchronous, i_rst_n low) empties both registers, returns the parser
// to hunting the first header byte and loads the header value 0xAA.
module sensor_frame_parser #(
    parameter int MAX_PAYLOAD = 5
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [7:0]  o_command_code,
    output logic [7:0]  o_material,
    output logic [15:0] o_distance,
    output logic [7:0]  o_strength,
    output logic [2:0]  o_payload_length
);
    import sfp_pkg::*;

    logic [7:0] r_header;
    t_byte_item item;
    logic       advance;
    logic       out_free;
    logic       emit;
    t_result    result;
    t_result    out_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header <= HEADER_RESET;
        end else if (i_cfg_we) begin
            r_header <= i_cfg_wdata;
        end
    end

    assign advance = item.valid & out_free;

    sfp_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .i_byte    (i_rx_byte),
        .i_advance (advance),
        .o_stall   (o_in_stall),
        .o_item    (item)
    );

    sfp_parse #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parse (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_header_value (r_header),
        .i_item         (item),
        .i_advance      (advance),
        .o_emit         (emit),
        .o_result       (result)
    );

    sfp_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_emit   (emit),
        .i_result (result),
        .i_stall  (i_out_stall),
        .o_free   (out_free),
        .o_valid  (o_out_valid),
        .o_result (out_result)
    );

    assign o_status         = out_result.status;
    assign o_command_code   = out_result.command_code;
    assign o_material       = out_result.material;
    assign o_distance       = out_result.distance;
    assign o_strength       = out_result.strength;
    assign o_payload_length = out_result.payload_length;

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (item.valid && !advance))
        else $error("input stalled without a waiting item");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && o_out_valid) |-> !i_out_stall)
        else $error("result emitted over a stalled result");

    a_result_from_parse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(emit && advance))
        else $error("result appeared without a parsed frame end");

endmodule

### tb/sv/tb_sensor_frame_parser.sv
`timescale 1ns / 100ps
// Self-checking testbench for sensor_frame_parser: random byte traffic with idle gaps
// and receiver stalls, results predicted per frame and checked in order.
// Depends on sfp_pkg and the sensor_frame_parser RTL.
module tb_sensor_frame_parser;
    import sfp_pkg::*;

    localparam int MAX_PAYLOAD = 5;

    class frame_result_model;
        logic [7:0] header;
        t_phase     phase;
        logic [7:0] sum;
        logic [7:0] cmd;
        logic [2:0] len;
        logic [2:0] idx;
        logic [7:0] payload_bytes [MAX_PAYLOAD];
        t_result    expected_frames [$];
        int         mismatches;
        int         frames_checked;

        function new();
            header = HEADER_RESET;
            phase = PH_HEAD1;
            sum = '0;
            cmd = '0;
            len = '0;
            idx = '0;
            mismatches = 0;
            frames_checked = 0;
        endfunction

        function void set_header(logic [7:0] value);
            header = value;
        endfunction

        function void close_frame(t_status st);
            t_result r;
            r = '0;
            r.status = st;
            r.command_code = cmd;
            r.payload_length = len;
            if (st == ST_GOOD) begin
                r.material = payload_bytes[0];
                r.distance = {payload_bytes[2], payload_bytes[1]};
                r.strength = payload_bytes[3];
            end
            expected_frames.push_back(r);
            phase = PH_HEAD1;
        endfunction

        function void take_byte(logic [7:0] b);
            case (phase)
                PH_HEAD1: begin
                    if (b == header) begin
                        sum = b;
                        phase = PH_HEAD2;
                    end
                end
                PH_HEAD2: begin
                    if (b == header) begin
                        sum = sum + b;
                        phase = PH_CMD;
                    end else begin
                        phase = PH_HEAD1;
                    end
                end
                PH_CMD: begin
                    cmd = b;
                    sum = sum + b;
                    phase = PH_LEN;
                end
                PH_LEN: begin
                    len = b[2:0];
                    sum = sum + b;
                    idx = '0;
                    if (b > MAX_PAYLOAD) begin
                        close_frame(ST_TOOLONG);
                    end else if (b == 8'd0) begin
                        phase = PH_SUM;
                    end else begin
                        phase = PH_DATA;
                    end
                end
                PH_DATA: begin
                    if (idx < MAX_PAYLOAD) begin
                        payload_bytes[idx] = b;
                    end
                    sum = sum + b;
                    idx = idx + 3'd1;
                    if (idx >= len) begin
                        phase = PH_SUM;
                    end
                end
                PH_SUM: begin
                    if (b != sum) begin
                        close_frame(ST_BADSUM);
                    end else if (len != 3'd4) begin
                        close_frame(ST_NOTFOUR);
                    end else begin
                        close_frame(ST_GOOD);
                    end
                end
                default: phase = PH_HEAD1;
            endcase
        endfunction

        task report(string what, int got, int want);
            mismatches++;
            if (mismatches <= 40) begin
                $display("ERROR at %0t: %s got 0x%0h, want 0x%0h", $realtime, what, got, want);
            end
        endtask

        task match_frame(t_result got);
            t_result want;
            if (expected_frames.size() == 0) begin
                report("result with none pending, status", got.status, -1);
                return;
            end
            want = expected_frames.pop_front();
            frames_checked++;
            if (got.status != want.status)
                report("status", got.status, want.status);
            if (got.command_code != want.command_code)
                report("command_code", got.command_code, want.command_code);
            if (got.material != want.material)
                report("material", got.material, want.material);
            if (got.distance != want.distance)
                report("distance", got.distance, want.distance);
            if (got.strength != want.strength)
                report("strength", got.strength, want.strength);
            if (got.payload_length != want.payload_length)
                report("payload_length", got.payload_length, want.payload_length);
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [7:0]  cfg_wdata = 8'd0;
    logic        in_valid = 1'b0;
    logic [7:0]  rx_byte = 8'd0;
    logic        out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [1:0]  o_status;
    logic [7:0]  o_command_code;
    logic [7:0]  o_material;
    logic [15:0] o_distance;
    logic [7:0]  o_strength;
    logic [2:0]  o_payload_length;

    frame_result_model frames;
    logic [7:0]        byte_plan [$];
    bit                no_gaps = 1'b0;
    int                hold_request = 0;
    int                bytes_sent = 0;
    int                headers_written = 0;

    sensor_frame_parser #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_wdata      (cfg_wdata),
        .i_in_valid       (in_valid),
        .o_in_stall       (o_in_stall),
        .i_rx_byte        (rx_byte),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (out_stall),
        .o_status         (o_status),
        .o_command_code   (o_command_code),
        .o_material       (o_material),
        .o_distance       (o_distance),
        .o_strength       (o_strength),
        .o_payload_length (o_payload_length)
    );

    always #2 clk = ~clk;

    function automatic void push_frame(logic [7:0] hdr, logic [7:0] cmd, logic [7:0] len,
                                       logic [63:0] pl, bit bad_sum);
        logic [7:0] sum;
        sum = hdr + hdr + cmd + len;
        byte_plan.push_back(hdr);
        byte_plan.push_back(hdr);
        byte_plan.push_back(cmd);
        byte_plan.push_back(len);
        if (len <= MAX_PAYLOAD) begin
            for (int i = 0; i < len; i++) begin
                byte_plan.push_back(pl[8*i +: 8]);
                sum = sum + pl[8*i +: 8];
            end
            if (bad_sum) begin
                sum = sum ^ 8'($urandom_range(1, 255));
            end
            byte_plan.push_back(sum);
        end
    endfunction

    function automatic void queue_traffic(logic [7:0] hdr, int n);
        int         sel;
        logic [7:0] len;
        while (byte_plan.size() < n) begin
            sel = $urandom_range(0, 99);
            if (sel < 70) begin
                len = 8'($urandom_range(0, 9));
                len = (len < 8'd4) ? 8'd4 : len - 8'd4;
                push_frame(hdr, 8'($urandom), len, {$urandom, $urandom},
                           $urandom_range(0, 4) == 0);
            end else if (sel < 80) begin
                len = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom_range(6, 255));
                push_frame(hdr, 8'($urandom), len, 64'd0, 1'b0);
            end else if (sel < 90) begin
                byte_plan.push_back(hdr);
                byte_plan.push_back(hdr ^ 8'($urandom_range(1, 255)));
            end else begin
                repeat ($urandom_range(1, 4)) byte_plan.push_back(8'($urandom));
            end
        end
    endfunction

    task automatic send_byte(logic [7:0] b);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        do @(posedge clk); while (!(in_valid && !o_in_stall));
        frames.take_byte(b);
        bytes_sent++;
    endtask

    task automatic send_plan();
        while (byte_plan.size() != 0) begin
            send_byte(byte_plan.pop_front());
        end
    endtask

    task automatic write_header(logic [7:0] value);
        in_valid <= 1'b0;
        while (frames.expected_frames.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        frames.set_header(value);
        cfg_we <= 1'b0;
        headers_written++;
    endtask

    task automatic run_traffic(logic [7:0] hdr, int n_bytes);
        int target;
        target = bytes_sent + n_bytes;
        while (bytes_sent < target) begin
            no_gaps = ($urandom_range(0, 3) == 0);
            queue_traffic(hdr, 30);
            send_plan();
        end
        no_gaps = 1'b0;
    endtask

    initial begin : result_sink
        int      gap;
        t_result got;
        wait (rst_n === 1'b1);
        forever begin
            if (hold_request > 0) begin
                gap = hold_request;
                hold_request = 0;
            end else begin
                gap = no_gaps ? 0 : $urandom_range(0, 8);
            end
            if (gap > 0) begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!(o_out_valid && !out_stall));
            got.status = t_status'(o_status);
            got.command_code = o_command_code;
            got.material = o_material;
            got.distance = o_distance;
            got.strength = o_strength;
            got.payload_length = o_payload_length;
            frames.match_frame(got);
        end
    end

    initial begin : stimulus
        logic [7:0] hdr;
        frames = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        byte_plan.push_back(8'h55);
        byte_plan.push_back(HEADER_RESET);
        byte_plan.push_back(8'h00);
        push_frame(HEADER_RESET, 8'hFF, 8'hFF, 64'd0, 1'b0);
        push_frame(HEADER_RESET, 8'h5A, 8'd4, 64'h00FF_00FF, 1'b0);
        push_frame(HEADER_RESET, 8'h33, 8'd1, 64'h80, 1'b1);
        byte_plan.push_back(HEADER_RESET);
        send_plan();

        // finish the open frame under the new header, zero-length payload
        write_header(8'h00);
        byte_plan.push_back(8'h00);
        byte_plan.push_back(8'h00);
        byte_plan.push_back(8'h00);
        byte_plan.push_back(HEADER_RESET);
        send_plan();
        run_traffic(8'h00, 150);

        write_header(8'hFF);
        hold_request = 400;
        no_gaps = 1'b1;
        queue_traffic(8'hFF, 60);
        send_plan();
        no_gaps = 1'b0;
        run_traffic(8'hFF, 100);

        hdr = 8'($urandom);
        write_header(hdr);
        run_traffic(hdr, 150);

        write_header(HEADER_RESET);
        run_traffic(HEADER_RESET, 150);

        in_valid <= 1'b0;
        while (frames.expected_frames.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        $display("Run: %0d bytes over %0d header values, %0d frame results checked.",
                 bytes_sent, headers_written + 1, frames.frames_checked);
        if (frames.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("Timed out waiting for the block");
        $display("Mismatches found");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/sfp_pkg.sv
hw/rtl/sfp_in_stage.sv
hw/rtl/sfp_parse.sv
hw/rtl/sfp_out_stage.sv
hw/rtl/sensor_frame_parser.sv
tb/sv/tb_sensor_frame_parser.sv
